// File: hdl/lcar_pkg.sv
// ============================================================================
// lcar_pkg - shared types and constants of the load cell converter reader
// Payload structs, register indexes, command codes, state encodings and the
// control and status bundles of the shared arithmetic unit.
// ============================================================================
package lcar_pkg;

  // Default values of the top level parameters
  localparam int DATA_BITS_DEF  = 24;
  localparam int TARE_READS_DEF = 10;

  // Fixed field widths
  localparam int RAW_W    = 24;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 32;
  localparam int READ_W   = 8;
  localparam int GAIN_W   = 2;
  localparam int PULSE_W  = 2;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Shared unit geometry: one 32-step loop for both divide and multiply
  localparam int ALU_W     = 32;
  localparam int PROD_W    = 2 * ALU_W;
  localparam int ALU_STEPS = 32;
  localparam int STEP_W    = $clog2(ALU_STEPS);
  localparam int FRAC_SHIFT = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0]     GAIN_RST    = 2'd0;
  localparam logic [READ_W-1:0]     SAMPLES_RST = 8'd1;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST   = 32'd65536;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TARE  = 2'd2;

  // Gain / channel codes
  localparam logic [GAIN_W-1:0] GAIN_A128 = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_A64  = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_B32  = 2'd2;

  // Saturation limits of the weight
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

  // Converter serial protocol phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_DHIGH = 3'd2,
    PH_DLOW  = 3'd3,
    PH_XHIGH = 3'd4,
    PH_XLOW  = 3'd5
  } phase_t;

  // Block sequencer
  typedef enum logic [2:0] {
    SQ_TICK,
    SQ_DIV,
    SQ_MAG,
    SQ_MUL,
    SQ_DONE
  } seq_t;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             dout_level;
  } in_t;

  typedef struct packed {
    logic                       sck_level;
    logic                       busy_res;
    logic                       result_valid;
    logic signed [WEIGHT_W-1:0] weight;
    logic [RAW_W-1:0]           raw_average;
    logic                       tare_done;
  } out_t;

  // Extra clock pulses after the data bits select the next gain or channel
  function automatic logic [PULSE_W-1:0] gain_pulses(input logic [GAIN_W-1:0] gain);
    logic [PULSE_W-1:0] pulses;
    case (gain)
      GAIN_A64: pulses = 2'd3;
      GAIN_B32: pulses = 2'd2;
      GAIN_A128: pulses = 2'd1;
      default: pulses = 2'd1;
    endcase
    return pulses;
  endfunction

endpackage

// File: hdl/load_cell_adc_reader_top.sv
// ============================================================================
// load_cell_adc_reader_top - serial bridge converter reader with weighing
// Drives the converter clock one half period per input transaction, shifts
// in conversions, averages them and scales the result to weight units.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in_     | input     | in_valid / in_stall | lcar_pkg::in_t (one tick)
//  out_    | output    | out_valid/out_stall | lcar_pkg::out_t (per tick)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  An ordinary tick updates the protocol state; its result sits in the output register
//  the next cycle, and a new tick is taken every cycle while it drains.
//  The tick that ends a sequence runs the shared 32-step adder loop, once
//  for a tare (divide) and twice for a weighing (divide and multiply),
//  during which in_stall stays high.
//  Reset is synchronous; no clearing pass is needed. cfg_ready is always high.
//  out_stall holds the output register; in_stall follows it when it is full.
//
module load_cell_adc_reader_top #(
  parameter int DATA_BITS  = lcar_pkg::DATA_BITS_DEF,
  parameter int TARE_READS = lcar_pkg::TARE_READS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lcar_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcar_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcar_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int BIT_W = $clog2(DATA_BITS + 1);
  localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

  // Configuration registers
  logic [lcar_pkg::GAIN_W-1:0]     gain_r;
  logic [lcar_pkg::READ_W-1:0]     samples_r;
  logic [lcar_pkg::CFG_DATA_W-1:0] scale_r;

  // Protocol state
  lcar_pkg::phase_t                phase_r, phase_nxt;
  logic                            is_tare_r, is_tare_nxt;
  logic [BIT_W-1:0]                bit_r, bit_nxt;
  logic [lcar_pkg::PULSE_W-1:0]    extra_r, extra_nxt;
  logic [lcar_pkg::READ_W-1:0]     read_r, read_nxt;
  logic [DATA_BITS-1:0]            shift_r, shift_nxt;
  logic [lcar_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [DATA_BITS-1:0]            tare_r;

  // Sequencer and arithmetic results
  lcar_pkg::seq_t                  seq_r, seq_nxt;
  logic [DATA_BITS-1:0]            avg_r;
  logic                            neg_r;
  logic                            out_valid_r;
  lcar_pkg::out_t                  out_data_r;

  logic                            in_acc;
  logic                            slot_free;
  logic                            tick_sck;
  logic                            tick_finish;
  logic [BIT_W-1:0]                bit_inc;
  logic                            bit_last;
  logic [lcar_pkg::PULSE_W-1:0]    extra_dec;
  logic [lcar_pkg::READ_W-1:0]     read_inc;
  logic [lcar_pkg::READ_W-1:0]     read_target;
  logic                            read_done;
  logic                            mag_neg;
  logic [DATA_BITS-1:0]            mag;
  logic [lcar_pkg::PROD_W-lcar_pkg::FRAC_SHIFT-1:0] scaled;
  logic                            scaled_ovf;
  logic [lcar_pkg::WEIGHT_W-1:0]   weight_sat;
  logic [lcar_pkg::ALU_W-1:0]      avg_ext;

  lcar_pkg::alu_cmd_t              alu_cmd;
  lcar_pkg::alu_sts_t              alu_sts;
  logic [lcar_pkg::ALU_W-1:0]      alu_operand;
  logic [lcar_pkg::ALU_W-1:0]      alu_quotient;
  logic [lcar_pkg::PROD_W-1:0]     alu_product;

  logic                            out_load;
  lcar_pkg::out_t                  out_nxt;

  // Handshake
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((seq_r == lcar_pkg::SQ_TICK) && slot_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= lcar_pkg::GAIN_RST;
      samples_r <= lcar_pkg::SAMPLES_RST;
      scale_r   <= lcar_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcar_pkg::CFG_GAIN:    gain_r    <= cfg_data[lcar_pkg::GAIN_W-1:0];
        lcar_pkg::CFG_SAMPLES: samples_r <= cfg_data[lcar_pkg::READ_W-1:0];
        lcar_pkg::CFG_SCALE:   scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counter helpers
  assign bit_inc   = bit_r + BIT_W'(1);
  assign bit_last  = bit_inc >= BIT_W'(DATA_BITS);
  assign extra_dec = (extra_r != '0) ? extra_r - 1'b1 : '0;
  assign read_inc  = read_r + 1'b1;
  always_comb begin
    if (is_tare_r) begin
      read_target = lcar_pkg::READ_W'(TARE_READS);
    end else if (samples_r == '0) begin
      read_target = lcar_pkg::READ_W'(1);
    end else begin
      read_target = samples_r;
    end
  end
  assign read_done = read_inc >= read_target;

  // Protocol phase: next state
  always_comb begin
    case (phase_r)
      lcar_pkg::PH_IDLE: begin
        if (in_data.command inside {lcar_pkg::CMD_WEIGH, lcar_pkg::CMD_TARE}) begin
          phase_nxt = lcar_pkg::PH_WAIT;
        end else begin
          phase_nxt = lcar_pkg::PH_IDLE;
        end
      end
      lcar_pkg::PH_WAIT: begin
        phase_nxt = in_data.dout_level ? lcar_pkg::PH_WAIT : lcar_pkg::PH_DLOW;
      end
      lcar_pkg::PH_DHIGH: phase_nxt = lcar_pkg::PH_DLOW;
      lcar_pkg::PH_DLOW: begin
        phase_nxt = bit_last ? lcar_pkg::PH_XHIGH : lcar_pkg::PH_DHIGH;
      end
      lcar_pkg::PH_XHIGH: phase_nxt = lcar_pkg::PH_XLOW;
      lcar_pkg::PH_XLOW: begin
        if (extra_dec != '0) begin
          phase_nxt = lcar_pkg::PH_XHIGH;
        end else if (read_done) begin
          phase_nxt = lcar_pkg::PH_IDLE;
        end else begin
          phase_nxt = lcar_pkg::PH_WAIT;
        end
      end
      default: phase_nxt = lcar_pkg::PH_IDLE;
    endcase
  end

  // Protocol phase: outputs
  always_comb begin
    tick_sck    = 1'b0;
    tick_finish = 1'b0;
    case (phase_r)
      lcar_pkg::PH_WAIT:  tick_sck = !in_data.dout_level;
      lcar_pkg::PH_DHIGH: tick_sck = 1'b1;
      lcar_pkg::PH_XHIGH: tick_sck = 1'b1;
      lcar_pkg::PH_XLOW:  tick_finish = (extra_dec == '0) && read_done;
      default: ;
    endcase
  end

  // Protocol datapath next values
  always_comb begin
    is_tare_nxt = is_tare_r;
    bit_nxt     = bit_r;
    extra_nxt   = extra_r;
    read_nxt    = read_r;
    shift_nxt   = shift_r;
    sum_nxt     = sum_r;
    case (phase_r)
      lcar_pkg::PH_IDLE: begin
        if (in_data.command inside {lcar_pkg::CMD_WEIGH, lcar_pkg::CMD_TARE}) begin
          is_tare_nxt = (in_data.command == lcar_pkg::CMD_TARE);
          read_nxt    = '0;
          sum_nxt     = '0;
        end
      end
      lcar_pkg::PH_WAIT: begin
        if (!in_data.dout_level) begin
          bit_nxt   = '0;
          shift_nxt = '0;
        end
      end
      lcar_pkg::PH_DLOW: begin
        shift_nxt = {shift_r[DATA_BITS-2:0], in_data.dout_level};
        bit_nxt   = bit_inc;
        if (bit_last) begin
          extra_nxt = lcar_pkg::gain_pulses(gain_r);
        end
      end
      lcar_pkg::PH_XLOW: begin
        extra_nxt = extra_dec;
        if (extra_dec == '0) begin
          sum_nxt  = sum_r + lcar_pkg::SUM_W'(shift_r ^ TOP_BIT);
          read_nxt = read_inc;
        end
      end
      default: ;
    endcase
  end

  // Advance protocol state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lcar_pkg::PH_IDLE;
      is_tare_r <= 1'b0;
      bit_r     <= '0;
      extra_r   <= '0;
      read_r    <= '0;
      shift_r   <= '0;
      sum_r     <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      is_tare_r <= is_tare_nxt;
      bit_r     <= bit_nxt;
      extra_r   <= extra_nxt;
      read_r    <= read_nxt;
      shift_r   <= shift_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // Offset magnitude and sign of the averaged reading
  assign mag_neg = avg_r < tare_r;
  assign mag     = mag_neg ? tare_r - avg_r : avg_r - tare_r;

  // Truncate Q48.16 product to Q.8 and saturate
  assign scaled     = alu_product[lcar_pkg::PROD_W-1:lcar_pkg::FRAC_SHIFT];
  assign scaled_ovf = |scaled[lcar_pkg::PROD_W-lcar_pkg::FRAC_SHIFT-1:lcar_pkg::WEIGHT_W-1];
  always_comb begin
    if (neg_r) begin
      weight_sat = scaled_ovf ? lcar_pkg::WEIGHT_MIN
                              : '0 - scaled[lcar_pkg::WEIGHT_W-1:0];
    end else begin
      weight_sat = scaled_ovf ? lcar_pkg::WEIGHT_MAX : scaled[lcar_pkg::WEIGHT_W-1:0];
    end
  end
  assign avg_ext = lcar_pkg::ALU_W'(avg_r);

  // Sequencer: next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      lcar_pkg::SQ_TICK: if (in_acc && tick_finish) seq_nxt = lcar_pkg::SQ_DIV;
      lcar_pkg::SQ_DIV: begin
        if (alu_sts.done) seq_nxt = is_tare_r ? lcar_pkg::SQ_DONE : lcar_pkg::SQ_MAG;
      end
      lcar_pkg::SQ_MAG: seq_nxt = lcar_pkg::SQ_MUL;
      lcar_pkg::SQ_MUL: if (alu_sts.done) seq_nxt = lcar_pkg::SQ_DONE;
      lcar_pkg::SQ_DONE: if (slot_free) seq_nxt = lcar_pkg::SQ_TICK;
      default: seq_nxt = lcar_pkg::SQ_TICK;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    alu_cmd.start = 1'b0;
    alu_cmd.op    = lcar_pkg::ALU_DIV;
    alu_operand   = sum_nxt;
    out_load      = 1'b0;
    out_nxt.sck_level    = tick_sck;
    out_nxt.busy_res     = (phase_nxt != lcar_pkg::PH_IDLE);
    out_nxt.result_valid = 1'b0;
    out_nxt.weight       = '0;
    out_nxt.raw_average  = '0;
    out_nxt.tare_done    = 1'b0;
    case (seq_r)
      lcar_pkg::SQ_TICK: begin
        if (in_acc) begin
          if (tick_finish) begin
            alu_cmd.start = 1'b1;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      lcar_pkg::SQ_MAG: begin
        alu_cmd.start = 1'b1;
        alu_cmd.op    = lcar_pkg::ALU_MUL;
        alu_operand   = lcar_pkg::ALU_W'(mag);
      end
      lcar_pkg::SQ_DONE: begin
        out_load             = slot_free;
        out_nxt.sck_level    = 1'b0;
        out_nxt.busy_res     = 1'b0;
        out_nxt.result_valid = !is_tare_r;
        out_nxt.weight       = is_tare_r ? '0 : weight_sat;
        out_nxt.raw_average  = avg_ext[lcar_pkg::RAW_W-1:0];
        out_nxt.tare_done    = is_tare_r;
      end
      default: ;
    endcase
  end

  // Sequencer state and output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= lcar_pkg::SQ_TICK;
      out_valid_r <= 1'b0;
      tare_r      <= '0;
    end else begin
      seq_r <= seq_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (out_load && (seq_r == lcar_pkg::SQ_DONE) && is_tare_r) begin
        tare_r <= avg_r;
      end
    end
  end

  // Capture payload and intermediate results
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    if ((seq_r == lcar_pkg::SQ_DIV) && alu_sts.done) begin
      avg_r <= alu_quotient[DATA_BITS-1:0];
    end
    if (seq_r == lcar_pkg::SQ_MAG) begin
      neg_r <= mag_neg;
    end
  end

  lcar_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (alu_cmd),
    .sts      (alu_sts),
    .operand  (alu_operand),
    .divisor  (read_r),
    .scale    (scale_r),
    .quotient (alu_quotient),
    .product  (alu_product)
  );

`ifndef SYNTHESIS
  // No tick is taken while arithmetic or the final result is pending
  a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != lcar_pkg::SQ_TICK) |-> in_stall)
    else $error("top: input taken during arithmetic");

  // The shared unit reports completion only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_sts.done |-> (seq_r == lcar_pkg::SQ_DIV || seq_r == lcar_pkg::SQ_MUL))
    else $error("top: unexpected arithmetic completion");

  // A weighing result and a tare completion never share a transaction
  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.result_valid && out_data_r.tare_done))
    else $error("top: weight and tare flagged together");

  // A finished sequence leaves the block idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.result_valid || out_data_r.tare_done))
      |-> !out_data_r.busy_res)
    else $error("top: busy flag on finishing transaction");

  // Leaving the result state always loads the output register
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == lcar_pkg::SQ_DONE && seq_nxt == lcar_pkg::SQ_TICK) |-> out_load)
    else $error("top: result dropped");
`endif

endmodule

// File: hdl/lcar_alu.sv
// ============================================================================
// lcar_alu - shared iterative divide / multiply unit
// One 33-bit adder serves a restoring divide (32-bit sum by 8-bit count) and
// a shift-add multiply (32 by 32 bits), one bit per cycle.
// ============================================================================
module lcar_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcar_pkg::alu_cmd_t           cmd,
  output lcar_pkg::alu_sts_t           sts,
  input  logic [lcar_pkg::ALU_W-1:0]   operand,
  input  logic [lcar_pkg::READ_W-1:0]  divisor,
  input  logic [lcar_pkg::ALU_W-1:0]   scale,
  output logic [lcar_pkg::ALU_W-1:0]   quotient,
  output logic [lcar_pkg::PROD_W-1:0]  product
);

  logic                            busy_r;
  logic                            done_r;
  logic [lcar_pkg::STEP_W-1:0]     step_r;
  lcar_pkg::alu_op_t               op_r;
  logic [lcar_pkg::ALU_W-1:0]      hi_r;
  logic [lcar_pkg::ALU_W-1:0]      lo_r;
  logic [lcar_pkg::READ_W-1:0]     rem_r;

  logic [lcar_pkg::READ_W:0]       shifted;
  logic [lcar_pkg::ALU_W:0]        add_a;
  logic [lcar_pkg::ALU_W:0]        add_b;
  logic                            add_cin;
  logic [lcar_pkg::ALU_W+1:0]      add_sum;

  // Select adder operands: trial subtract for divide, partial product for multiply
  always_comb begin
    shifted = {rem_r, lo_r[lcar_pkg::ALU_W-1]};
    case (op_r)
      lcar_pkg::ALU_DIV: begin
        add_a   = (lcar_pkg::ALU_W+1)'(shifted);
        add_b   = ~((lcar_pkg::ALU_W+1)'(divisor));
        add_cin = 1'b1;
      end
      lcar_pkg::ALU_MUL: begin
        add_a   = {1'b0, hi_r};
        add_b   = lo_r[0] ? {1'b0, scale} : '0;
        add_cin = 1'b0;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b} + (lcar_pkg::ALU_W+2)'(add_cin);
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == lcar_pkg::STEP_W'(lcar_pkg::ALU_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands on start, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      lo_r  <= operand;
      hi_r  <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      case (op_r)
        lcar_pkg::ALU_DIV: begin
          if (add_sum[lcar_pkg::ALU_W+1]) begin
            rem_r <= add_sum[lcar_pkg::READ_W-1:0];
            lo_r  <= {lo_r[lcar_pkg::ALU_W-2:0], 1'b1};
          end else begin
            rem_r <= shifted[lcar_pkg::READ_W-1:0];
            lo_r  <= {lo_r[lcar_pkg::ALU_W-2:0], 1'b0};
          end
        end
        lcar_pkg::ALU_MUL: begin
          hi_r <= add_sum[lcar_pkg::ALU_W:1];
          lo_r <= {add_sum[0], lo_r[lcar_pkg::ALU_W-1:1]};
        end
        default: begin
          lo_r <= lo_r;
        end
      endcase
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = lo_r;
  assign product  = {hi_r, lo_r};

`ifndef SYNTHESIS
  // A new operation never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("lcar_alu: start while busy");

  // Completion follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("lcar_alu: done without a running operation");

  // Busy and done are never high together
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("lcar_alu: busy and done overlap");
`endif

endmodule
